[design/itl_pkg.sv]
package itl_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_QUERY = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  // Broadcast write of one table entry into the cell picked by addr.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [31:0]      start_ofs;
    logic [31:0]      end_ofs;
    logic [31:0]      time_ms;
    logic [32:0]      stop_ms;
  } wr_t;

  // Search token that walks the chain, one cell a cycle.
  typedef struct packed {
    logic             active;
    logic             mode_time;
    logic [31:0]      probe;
    logic             found;
    logic [31:0]      best_key;
    logic [IDX_W-1:0] best_idx;
    logic             best_cover;
  } token_t;

endpackage

[design/interval_table_lookup_unit.sv]
// Add and tick: the result (add only) is in the output register the cycle after acceptance.
// Query: a search token walks the chain of ENTRIES cells, one cell per cycle, and the
// output register captures the result from the chain's tail; empty-table and no-flag
// queries are answered directly into the output register. One item is in work at a time.
// Reset (rst, synchronous): clears entry count, both flags, the ms counter and all control;
// the table contents are not reset and are never read before being written.
module interval_table_lookup_unit
  import itl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [31:0] entry_start,
  input  logic [31:0] entry_end,
  input  logic [31:0] entry_time,
  input  logic [31:0] entry_duration,
  input  logic [31:0] query_key,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        accepted,
  output logic        hit,
  output logic [5:0]  entry_index
);

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] entry_count;
  logic             any_offset_flag;
  logic             any_time_flag;
  logic [31:0]      elapsed_ms;

  logic             in_take;
  logic             is_add;
  logic             is_query;
  logic             is_tick;
  logic             room;
  logic             need_scan;
  logic             time_mode;
  logic             clear_ms;
  wr_t              wr;
  token_t           tok [ENTRIES+1];

  // Hold off new transactions during a scan, and while a result waits downstream.
  assign in_stall = (state == ST_SCAN) || (out_valid && out_stall);
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    is_add   = 1'b0;
    is_query = 1'b0;
    is_tick  = 1'b0;
    unique case (req_type)
      REQ_ADD:   is_add   = 1'b1;
      REQ_QUERY: is_query = 1'b1;
      REQ_TICK:  is_tick  = 1'b1;
      default:   ;
    endcase
  end

  assign room      = entry_count < CNT_W'(ENTRIES);
  assign time_mode = !any_offset_flag && any_time_flag;
  // Only a nonempty table with a flag set needs the chain.
  assign need_scan = (entry_count != '0) && (any_offset_flag || any_time_flag);
  assign clear_ms  = in_take && is_query && (entry_count != '0) && time_mode &&
                     (query_key == 32'd0);

  // Write port: the cell at the current fill level latches the new entry.
  always_comb begin
    wr.en        = in_take && is_add && room;
    wr.addr      = IDX_W'(entry_count);
    wr.start_ofs = entry_start;
    wr.end_ofs   = entry_end;
    wr.time_ms   = entry_time;
    wr.stop_ms   = {1'b0, entry_time} + {1'b0, entry_duration};
  end

  // Launch the search token into the head of the chain.
  always_comb begin
    tok[0].active     = in_take && is_query && need_scan;
    tok[0].mode_time  = time_mode;
    tok[0].probe      = time_mode ? (clear_ms ? 32'd0 : elapsed_ms) : query_key;
    tok[0].found      = 1'b0;
    tok[0].best_key   = '0;
    tok[0].best_idx   = '0;
    tok[0].best_cover = 1'b0;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    itl_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cell_id     (IDX_W'(i)),
      .entry_count (entry_count),
      .wr          (wr),
      .tok_in      (tok[i]),
      .tok_out     (tok[i+1])
    );
  end

  // Table bookkeeping and the saturating ms counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count     <= '0;
      any_offset_flag <= 1'b0;
      any_time_flag   <= 1'b0;
      elapsed_ms      <= '0;
    end else begin
      if (wr.en) begin
        entry_count <= entry_count + CNT_W'(1);
        if (entry_start != 32'd0) begin
          any_offset_flag <= 1'b1;
        end
        if (entry_time != 32'd0) begin
          any_time_flag <= 1'b1;
        end
      end
      if (clear_ms) begin
        elapsed_ms <= '0;
      end else if (in_take && is_tick && (elapsed_ms != 32'hFFFF_FFFF)) begin
        elapsed_ms <= elapsed_ms + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (tok[0].active) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tok[ENTRIES].active) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Output register. It is always free when a scan finishes, since a query
  // only starts when the register is empty or draining.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((in_take && (is_add || (is_query && !need_scan))) ||
                 tok[ENTRIES].active) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tok[ENTRIES].active) begin
      accepted    <= 1'b0;
      hit         <= tok[ENTRIES].found && tok[ENTRIES].best_cover;
      entry_index <= (tok[ENTRIES].found && tok[ENTRIES].best_cover) ?
                     6'(tok[ENTRIES].best_idx) : 6'd0;
    end else if (in_take && is_add) begin
      accepted    <= room;
      hit         <= 1'b0;
      entry_index <= 6'd0;
    end else if (in_take && is_query && !need_scan) begin
      // empty table misses; no flag set hits entry 0
      accepted    <= 1'b0;
      hit         <= entry_count != '0;
      entry_index <= 6'd0;
    end
  end

  a_scan_stalls: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> in_stall)
    else $error("input taken during a scan");

  a_tail_in_scan: assert property (@(posedge clk) disable iff (rst)
    tok[ENTRIES].active |-> (state == ST_SCAN))
    else $error("token left the chain outside a scan");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(ENTRIES))
    else $error("entry count above table size");

  a_out_free_at_tail: assert property (@(posedge clk) disable iff (rst)
    tok[ENTRIES].active |-> !out_valid)
    else $error("scan result would overwrite a pending result");

  a_hit_not_add: assert property (@(posedge clk) disable iff (rst)
    (out_valid && hit) |-> !accepted)
    else $error("result flags both hit and accepted");

endmodule

[design/itl_cell.sv]
module itl_cell
  import itl_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] cell_id,
  input  logic [CNT_W-1:0] entry_count,
  input  wr_t              wr,
  input  token_t           tok_in,
  output token_t           tok_out
);

  logic [31:0] start_ofs;
  logic [31:0] end_ofs;
  logic [31:0] time_ms;
  logic [32:0] stop_ms;

  logic        filled;
  logic [31:0] sel_key;
  logic        in_range;
  logic        take;
  token_t      tok_next;

  always_ff @(posedge clk) begin
    if (wr.en && (wr.addr == cell_id)) begin
      start_ofs <= wr.start_ofs;
      end_ofs   <= wr.end_ofs;
      time_ms   <= wr.time_ms;
      stop_ms   <= wr.stop_ms;
    end
  end

  always_comb begin
    filled  = CNT_W'(cell_id) < entry_count;
    sel_key = tok_in.mode_time ? time_ms : start_ofs;
    if (tok_in.mode_time) begin
      in_range = stop_ms >= {1'b0, tok_in.probe};
    end else begin
      in_range = (end_ofs == 32'd0) || (end_ofs >= tok_in.probe);
    end
    // strictly greater replaces, so the lowest index keeps a tie
    take = filled && (sel_key <= tok_in.probe) &&
           (!tok_in.found || (sel_key > tok_in.best_key));
    tok_next = tok_in;
    if (take) begin
      tok_next.found      = 1'b1;
      tok_next.best_key   = sel_key;
      tok_next.best_idx   = cell_id;
      tok_next.best_cover = in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.active <= 1'b0;
    end else begin
      tok_out.active <= tok_next.active;
    end
    tok_out.mode_time  <= tok_next.mode_time;
    tok_out.probe      <= tok_next.probe;
    tok_out.found      <= tok_next.found;
    tok_out.best_key   <= tok_next.best_key;
    tok_out.best_idx   <= tok_next.best_idx;
    tok_out.best_cover <= tok_next.best_cover;
  end

endmodule
